// ===== rtl/dht_pkg.sv =====
// ----------------------------------------------------------------------------
// dht_pkg
// Shared constants and codes for the double hashing key/value table.
// ----------------------------------------------------------------------------
package dht_pkg;

    localparam int DHT_TABLE_DEPTH = 64;
    localparam int DHT_KEY_WIDTH   = 32;
    localparam int DHT_VALUE_WIDTH = 32;

    localparam int CFG_W = 7;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RST  = 7'd61;
    localparam logic [CFG_W-1:0] PROBE_LIMIT_RST = 7'd6;

    localparam logic CFG_TABLE_SIZE  = 1'b0;
    localparam logic CFG_PROBE_LIMIT = 1'b1;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_LIVE    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

endpackage

// ===== rtl/double_hash_table_engine.sv =====
// ----------------------------------------------------------------------------
// double_hash_table_engine
// Key/value table with open addressing, double hashing and tombstones.
// ----------------------------------------------------------------------------
// One request at a time. After reset the slot marks are cleared one after
// another in S_CLEAR, during which no request beat is taken. Each request
// then computes the two key remainders (one bit per cycle on a shared
// restoring divider), does each probe as a registered slot memory read and
// then a compare, and commits in S_FINISH once the output register is free;
// a REQ_NONE request goes straight to S_FINISH. The engine then returns to
// idle for the next request beat. A finished result waits in the output
// register while the next request is accepted.
module double_hash_table_engine
    import dht_pkg::*;
#(
    parameter int TABLE_DEPTH = DHT_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DHT_KEY_WIDTH,
    parameter int VALUE_WIDTH = DHT_VALUE_WIDTH,
    localparam int IDX_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             req_type,
    input  logic [KEY_WIDTH-1:0]   key_in,
    input  logic [VALUE_WIDTH-1:0] value_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic [VALUE_WIDTH-1:0] read_value,
    output logic [IDX_W-1:0]       slot_index,
    output logic [CNT_W-1:0]       entry_count
);

    localparam int NW   = IDX_W + 1;
    localparam int BC_W = $clog2(KEY_WIDTH);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_DIV_H1  = 3'd2;
    localparam logic [2:0] S_DIV_H2  = 3'd3;
    localparam logic [2:0] S_PROBE_A = 3'd4;
    localparam logic [2:0] S_PROBE_B = 3'd5;
    localparam logic [2:0] S_FINISH  = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [CFG_W-1:0]       table_size_reg, probe_limit_reg;
    logic [NW-1:0]          clr_cnt_reg, clr_cnt_next;

    logic [1:0]             req_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [NW-1:0]          n_reg;
    logic [CFG_W-1:0]       lim_reg;

    logic [KEY_WIDTH-1:0]   shift_reg, shift_next;
    logic [NW-1:0]          rem_reg, rem_next;
    logic [NW-1:0]          div_reg, div_next;
    logic [BC_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [NW-1:0]          h1_reg, h1_next;
    logic [NW-1:0]          h2_reg, h2_next;
    logic [NW-1:0]          pos_reg, pos_next;
    logic [CFG_W-1:0]       probe_cnt_reg, probe_cnt_next;
    logic                   hit_reg, hit_next;
    logic                   empty_reg, empty_next;
    logic                   have_del_reg, have_del_next;
    logic [IDX_W-1:0]       del_slot_reg, del_slot_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             status_reg, status_next;
    logic [VALUE_WIDTH-1:0] read_value_reg, read_value_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;

    logic [1:0]             mark_mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]   key_mem  [TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] val_mem  [TABLE_DEPTH];
    logic [1:0]             mark_rd_reg;
    logic [KEY_WIDTH-1:0]   key_rd_reg;
    logic [VALUE_WIDTH-1:0] val_rd_reg;

    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   mark_we;
    logic [IDX_W-1:0]       mark_wa;
    logic [1:0]             mark_wd;
    logic                   key_we;
    logic                   val_we;
    logic [IDX_W-1:0]       kv_wa;

    logic                   in_fire;
    logic [31:0]            ts_w;
    logic [31:0]            n_use;
    logic [NW-1:0]          rem_sh;
    logic [NW-1:0]          rem_step;
    logic [NW-1:0]          pos_sum;
    logic [NW-1:0]          pos_wrap;
    logic                   out_free;

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == S_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign slot_index  = slot_reg;
    assign entry_count = count_reg;

    assign ts_w  = {{(32 - CFG_W){1'b0}}, table_size_reg};
    assign n_use = (ts_w < 32'd3) ? 32'd3 :
                   (ts_w > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : ts_w;

    assign rem_sh   = {rem_reg[NW-2:0], shift_reg[KEY_WIDTH-1]};
    assign rem_step = (rem_sh >= div_reg) ? (rem_sh - div_reg) : rem_sh;

    assign pos_sum  = pos_reg + h2_reg;
    assign pos_wrap = (pos_sum >= n_reg) ? (pos_sum - n_reg) : pos_sum;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        shift_next      = shift_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        bit_cnt_next    = bit_cnt_reg;
        h1_next         = h1_reg;
        h2_next         = h2_reg;
        pos_next        = pos_reg;
        probe_cnt_next  = probe_cnt_reg;
        hit_next        = hit_reg;
        empty_next      = empty_reg;
        have_del_next   = have_del_reg;
        del_slot_next   = del_slot_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        slot_next       = slot_reg;
        rd_en           = 1'b0;
        rd_addr         = pos_wrap[IDX_W-1:0];
        mark_we         = 1'b0;
        mark_wa         = pos_reg[IDX_W-1:0];
        mark_wd         = MARK_EMPTY;
        key_we          = 1'b0;
        val_we          = 1'b0;
        kv_wa           = pos_reg[IDX_W-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                mark_we      = 1'b1;
                mark_wa      = clr_cnt_reg[IDX_W-1:0];
                mark_wd      = MARK_EMPTY;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == NW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    shift_next    = key_in;
                    rem_next      = '0;
                    div_next      = n_use[NW-1:0];
                    bit_cnt_next  = '0;
                    hit_next      = 1'b0;
                    empty_next    = 1'b0;
                    have_del_next = 1'b0;
                    state_next    = (req_type == REQ_NONE) ? S_FINISH : S_DIV_H1;
                end
            end
            S_DIV_H1:
            begin
                rem_next     = rem_step;
                shift_next   = {shift_reg[KEY_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BC_W'(KEY_WIDTH - 1))
                begin
                    h1_next      = rem_step;
                    rem_next     = '0;
                    shift_next   = key_reg;
                    div_next     = n_reg - NW'(2);
                    bit_cnt_next = '0;
                    state_next   = S_DIV_H2;
                end
            end
            S_DIV_H2:
            begin
                rem_next     = rem_step;
                shift_next   = {shift_reg[KEY_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BC_W'(KEY_WIDTH - 1))
                begin
                    h2_next        = rem_step + 1'b1;
                    pos_next       = h1_reg;
                    probe_cnt_next = 7'd1;
                    state_next     = S_PROBE_A;
                end
            end
            S_PROBE_A:
            begin
                rd_en      = 1'b1;
                pos_next   = pos_wrap;
                state_next = S_PROBE_B;
            end
            S_PROBE_B:
            begin
                if (mark_rd_reg == MARK_EMPTY)
                begin
                    empty_next = 1'b1;
                    state_next = S_FINISH;
                end
                else if (mark_rd_reg == MARK_LIVE && key_rd_reg == key_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    if (mark_rd_reg != MARK_LIVE && !have_del_reg)
                    begin
                        have_del_next = 1'b1;
                        del_slot_next = pos_reg[IDX_W-1:0];
                    end
                    if (probe_cnt_reg == lim_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        probe_cnt_next = probe_cnt_reg + 1'b1;
                        state_next     = S_PROBE_A;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    read_value_next = '0;
                    slot_next       = '0;
                    status_next     = ST_NOTFOUND;
                    state_next      = S_IDLE;
                    unique case (req_reg) inside
                        REQ_INSERT:
                        begin
                            if (hit_reg)
                            begin
                                val_we      = 1'b1;
                                status_next = ST_OK;
                                slot_next   = pos_reg[IDX_W-1:0];
                            end
                            else if (have_del_reg || empty_reg)
                            begin
                                kv_wa       = have_del_reg ? del_slot_reg
                                                           : pos_reg[IDX_W-1:0];
                                key_we      = 1'b1;
                                val_we      = 1'b1;
                                mark_we     = 1'b1;
                                mark_wa     = kv_wa;
                                mark_wd     = MARK_LIVE;
                                count_next  = count_reg + 1'b1;
                                status_next = ST_OK;
                                slot_next   = kv_wa;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        REQ_LOOKUP, REQ_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                status_next = ST_OK;
                                slot_next   = pos_reg[IDX_W-1:0];
                                if (req_reg == REQ_LOOKUP)
                                begin
                                    read_value_next = val_rd_reg;
                                end
                                else
                                begin
                                    mark_we = 1'b1;
                                    mark_wd = MARK_DELETED;
                                    if (count_reg != '0)
                                    begin
                                        count_next = count_reg - 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                status_next = empty_reg ? ST_NOTFOUND : ST_FULL;
                            end
                        end
                        default:
                        begin
                            status_next = ST_NOTFOUND;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            table_size_reg  <= TABLE_SIZE_RST;
            probe_limit_reg <= PROBE_LIMIT_RST;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TABLE_SIZE)
                begin
                    table_size_reg <= cfg_data;
                end
                else
                begin
                    probe_limit_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req_type;
            key_reg <= key_in;
            val_reg <= value_in;
            n_reg   <= n_use[NW-1:0];
            lim_reg <= (probe_limit_reg == '0) ? 7'd1 : probe_limit_reg;
        end
        shift_reg       <= shift_next;
        rem_reg         <= rem_next;
        div_reg         <= div_next;
        bit_cnt_reg     <= bit_cnt_next;
        h1_reg          <= h1_next;
        h2_reg          <= h2_next;
        pos_reg         <= pos_next;
        probe_cnt_reg   <= probe_cnt_next;
        hit_reg         <= hit_next;
        empty_reg       <= empty_next;
        have_del_reg    <= have_del_next;
        del_slot_reg    <= del_slot_next;
        status_reg      <= status_next;
        read_value_reg  <= read_value_next;
        slot_reg        <= slot_next;
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_wa] <= mark_wd;
        end
        if (rd_en)
        begin
            mark_rd_reg <= mark_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[kv_wa] <= key_reg;
        end
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[kv_wa] <= val_reg;
        end
        if (rd_en)
        begin
            val_rd_reg <= val_mem[rd_addr];
        end
    end

    a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> slot_index == '0)
        else $error("slot index nonzero on failed request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    a_value_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> read_value == '0)
        else $error("read value nonzero on failed request");

endmodule
